// File: sv/treu_pkg.sv
`timescale 1ns / 1ps

package treu_pkg;

    localparam int SIDE_WIDTH_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int WIDE_W  = 128;
    localparam int ROOT_W  = 64;
    localparam int CHUNK_W = 32;

    localparam int LIMIT_W = 7;
    localparam int STOP_W  = 16;
    localparam int CFG_W   = 16;

    localparam logic REG_ITER_LIMIT = 1'b0;
    localparam logic REG_STOP_WIDTH = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd48;
    localparam logic [STOP_W-1:0]  STOP_RESET  = 16'd1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOT_TRI = 2'd1;
    localparam logic [1:0] STAT_NEG_RAD = 2'd2;

    // last partial-product index: 3 for a 64-bit multiplicand, 7 for 128-bit
    localparam logic [2:0] MUL_LAST_NARROW = 3'd3;
    localparam logic [2:0] MUL_LAST_WIDE   = 3'd7;

    typedef struct packed {
        logic       start;
        logic [2:0] last_k;
    } mul_ctl_t;

endpackage

// File: sv/treu_mul.sv
`timescale 1ns / 1ps

module treu_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  treu_pkg::mul_ctl_t         ctl,
    input  logic [treu_pkg::WIDE_W-1:0] a,
    input  logic [treu_pkg::ROOT_W-1:0] b,
    output logic                       done,
    output logic [treu_pkg::WIDE_W-1:0] prod
);
    import treu_pkg::*;

    logic                  issue_reg;
    logic [2:0]            k_reg;
    logic [2:0]            last_k_reg;
    logic                  ppv_reg;
    logic                  pplast_reg;
    logic                  done_reg;
    logic [2*CHUNK_W-1:0]  pp_reg;
    logic [2:0]            sh_reg;
    logic [WIDE_W-1:0]     acc_reg;

    logic [1:0]            idx_a;
    logic                  idx_b;
    logic [CHUNK_W-1:0]    a_ch;
    logic [CHUNK_W-1:0]    b_ch;
    logic [2*CHUNK_W-1:0]  pp_next;
    logic [2:0]            sh_next;
    logic [WIDE_W-1:0]     pp_shifted;

    always_comb
    begin
        idx_a      = k_reg[2:1];
        idx_b      = k_reg[0];
        a_ch       = a[CHUNK_W*idx_a +: CHUNK_W];
        b_ch       = b[CHUNK_W*idx_b +: CHUNK_W];
        pp_next    = a_ch * b_ch;
        sh_next    = {1'b0, idx_a} + {2'b00, idx_b};
        // weights of 2^128 and above drop out of the truncated product
        pp_shifted = sh_reg[2] ? '0 : ({{(WIDE_W-2*CHUNK_W){1'b0}}, pp_reg}
                                       << {sh_reg[1:0], 5'b00000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            k_reg      <= '0;
            last_k_reg <= '0;
            ppv_reg    <= 1'b0;
            pplast_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (ctl.start)
        begin
            issue_reg  <= 1'b1;
            k_reg      <= '0;
            last_k_reg <= ctl.last_k;
            ppv_reg    <= 1'b0;
            pplast_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= ppv_reg && pplast_reg;
            ppv_reg    <= issue_reg;
            pplast_reg <= issue_reg && (k_reg == last_k_reg);
            if (issue_reg)
            begin
                k_reg <= k_reg + 3'd1;
                if (k_reg == last_k_reg)
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= pp_next;
        sh_reg <= sh_next;
        if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (ppv_reg)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: sv/treu_div.sv
`timescale 1ns / 1ps

module treu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [treu_pkg::WIDE_W-1:0] numer,
    input  logic [treu_pkg::ROOT_W-1:0] denom,
    output logic                        done,
    output logic [treu_pkg::WIDE_W-1:0] quot
);
    import treu_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDE_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WIDE_W-1:0]  n_reg;
    logic [WIDE_W-1:0]  q_reg;
    logic [ROOT_W-1:0]  rem_reg;

    logic [ROOT_W:0]    trial;
    logic [ROOT_W:0]    diff;
    logic               ge;

    always_comb
    begin
        trial = {rem_reg, n_reg[WIDE_W-1]};
        diff  = trial - {1'b0, denom};
        ge    = trial >= {1'b0, denom};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // zero divisor: answer all ones at once
                busy_reg <= (denom != '0);
                done_reg <= (denom == '0);
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= numer;
            q_reg   <= (denom == '0) ? '1 : '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[WIDE_W-2:0], 1'b0};
            rem_reg <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
            q_reg   <= {q_reg[WIDE_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: sv/triangle_radii_euler_distance_unit.sv
`timescale 1ns / 1ps

// Triangle radii and Euler distance. Takes three unsigned fixed-point side
// lengths and returns the inradius, the circumradius and the incenter to
// circumcenter distance, truncated and saturated, with a status code (not a
// triangle or zero area; negative distance radicand). One request is worked
// at a time and in_stall stays high until its result is taken. All products
// go through one 32x32 multiplier; the two square roots are bisections of up
// to iteration_limit steps, each one multiplier pass with its test; the two
// divisions run one quotient bit a cycle for a 128-bit quotient. With the reset
// registers the time a request takes is set mostly by its up to 96 bisection
// steps on the multiplier; a non-triangle shows its result the cycle after the
// request is taken.
module triangle_radii_euler_distance_unit #(
    parameter int SIDE_WIDTH    = treu_pkg::SIDE_WIDTH_DEF,
    parameter int FRACTION_BITS = treu_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [treu_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [SIDE_WIDTH-1:0]      side_a,
    input  logic [SIDE_WIDTH-1:0]      side_b,
    input  logic [SIDE_WIDTH-1:0]      side_c,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SIDE_WIDTH-1:0]      in_radius,
    output logic [SIDE_WIDTH-1:0]      circum_radius,
    output logic [SIDE_WIDTH-1:0]      center_distance,
    output logic [1:0]                 status
);
    import treu_pkg::*;

    localparam int RINT_W = SIDE_WIDTH + 16;
    localparam logic [ROOT_W-1:0] OUT_MAX = (64'd1 << SIDE_WIDTH) - 64'd1;
    localparam logic [ROOT_W-1:0] ONE     = 64'd1 << FRACTION_BITS;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_M1      = 15'b000000000000010,
        S_M2      = 15'b000000000000100,
        S_M3      = 15'b000000000001000,
        S_SQ_INIT = 15'b000000000010000,
        S_SQ_TEST = 15'b000000000100000,
        S_SQ_MUL  = 15'b000000001000000,
        S_SQ_END  = 15'b000000010000000,
        S_D1      = 15'b000000100000000,
        S_M4      = 15'b000001000000000,
        S_M5      = 15'b000010000000000,
        S_D2      = 15'b000100000000000,
        S_M6      = 15'b001000000000000,
        S_M7      = 15'b010000000000000,
        S_OUT     = 15'b100000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [STOP_W-1:0]    stop_reg;
    logic                 mstart_reg, mstart_next;
    logic [2:0]           mlast_reg, mlast_next;
    logic                 dstart_reg, dstart_next;

    logic [SIDE_WIDTH-1:0] a_reg, a_next;
    logic [SIDE_WIDTH-1:0] b_reg, b_next;
    logic [SIDE_WIDTH-1:0] c_reg, c_next;
    logic [ROOT_W-1:0]    sum_reg, sum_next;
    logic [WIDE_W-1:0]    x_reg, x_next;
    logic [ROOT_W-1:0]    low_reg, low_next;
    logic [ROOT_W-1:0]    high_reg, high_next;
    logic [LIMIT_W-1:0]   steps_reg, steps_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic                 sel_reg, sel_next;
    logic [ROOT_W-1:0]    area_reg, area_next;
    logic [ROOT_W-1:0]    rin_reg, rin_next;
    logic [RINT_W-1:0]    rint_reg, rint_next;
    logic [WIDE_W-1:0]    rsq_reg, rsq_next;
    logic [WIDE_W-1:0]    ma_reg, ma_next;
    logic [ROOT_W-1:0]    mb_reg, mb_next;
    logic [WIDE_W-1:0]    dnum_reg, dnum_next;
    logic [ROOT_W-1:0]    dden_reg, dden_next;
    logic [SIDE_WIDTH-1:0] rin_out_reg, rin_out_next;
    logic [SIDE_WIDTH-1:0] rc_out_reg, rc_out_next;
    logic [SIDE_WIDTH-1:0] dist_out_reg, dist_out_next;
    logic [1:0]           status_reg, status_next;

    mul_ctl_t             mctl;
    logic                 mdone;
    logic [WIDE_W-1:0]    mprod;
    logic                 ddone;
    logic [WIDE_W-1:0]    dquot;

    logic [ROOT_W-1:0]    sa, sb, sc, sum_in;
    logic [ROOT_W-1:0]    ra, rb, rc;
    logic                 bad_tri;
    logic [WIDE_W-1:0]    hx;
    logic [ROOT_W-1:0]    high_init;
    logic [ROOT_W-1:0]    span;
    logic [ROOT_W-1:0]    half;
    logic [WIDE_W-1:0]    two_rr;
    logic [RINT_W-1:0]    rint_sat;

    assign mctl.start  = mstart_reg;
    assign mctl.last_k = mlast_reg;

    treu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .a     (ma_reg),
        .b     (mb_reg),
        .done  (mdone),
        .prod  (mprod)
    );

    treu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart_reg),
        .numer (dnum_reg),
        .denom (dden_reg),
        .done  (ddone),
        .quot  (dquot)
    );

    always_comb
    begin
        sa        = ROOT_W'(side_a);
        sb        = ROOT_W'(side_b);
        sc        = ROOT_W'(side_c);
        sum_in    = sa + sb + sc;
        bad_tri   = ((sa << 1) >= sum_in) || ((sb << 1) >= sum_in) ||
                    ((sc << 1) >= sum_in);
        ra        = ROOT_W'(a_reg);
        rb        = ROOT_W'(b_reg);
        rc        = ROOT_W'(c_reg);
        hx        = x_reg >> FRACTION_BITS;
        high_init = (hx[WIDE_W-1:ROOT_W] != '0) ? '1 : hx[ROOT_W-1:0];
        if (high_init < ONE)
        begin
            high_init = ONE;
        end
        span      = high_reg - low_reg;
        half      = low_reg + (span >> 1);
        two_rr    = mprod << 1;
        rint_sat  = (dquot[WIDE_W-1:RINT_W] != '0) ? '1 : dquot[RINT_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        mstart_next   = 1'b0;
        mlast_next    = mlast_reg;
        dstart_next   = 1'b0;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        steps_next    = steps_reg;
        root_next     = root_reg;
        sel_next      = sel_reg;
        area_next     = area_reg;
        rin_next      = rin_reg;
        rint_next     = rint_reg;
        rsq_next      = rsq_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        dnum_next     = dnum_reg;
        dden_next     = dden_reg;
        rin_out_next  = rin_out_reg;
        rc_out_next   = rc_out_reg;
        dist_out_next = dist_out_reg;
        status_next   = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next   = side_a;
                    b_next   = side_b;
                    c_next   = side_c;
                    sum_next = sum_in;
                    if (bad_tri)
                    begin
                        rin_out_next  = '0;
                        rc_out_next   = '0;
                        dist_out_next = '0;
                        status_next   = STAT_NOT_TRI;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        ma_next     = WIDE_W'(sum_in);
                        mb_next     = sum_in - (sa << 1);
                        mlast_next  = MUL_LAST_NARROW;
                        mstart_next = 1'b1;
                        state_next  = S_M1;
                    end
                end
            end
            S_M1:
            begin
                if (mdone)
                begin
                    ma_next     = mprod;
                    mb_next     = sum_reg - (rb << 1);
                    mlast_next  = MUL_LAST_WIDE;
                    mstart_next = 1'b1;
                    state_next  = S_M2;
                end
            end
            S_M2:
            begin
                if (mdone)
                begin
                    ma_next     = mprod;
                    mb_next     = sum_reg - (rc << 1);
                    mlast_next  = MUL_LAST_WIDE;
                    mstart_next = 1'b1;
                    state_next  = S_M3;
                end
            end
            S_M3:
            begin
                if (mdone)
                begin
                    // 16*area^2 in Q.4F down to area^2 in Q.2F
                    x_next     = mprod >> (2*FRACTION_BITS + 4);
                    sel_next   = 1'b0;
                    state_next = S_SQ_INIT;
                end
            end
            S_SQ_INIT:
            begin
                if (x_reg == '0)
                begin
                    root_next  = '0;
                    state_next = S_SQ_END;
                end
                else
                begin
                    low_next   = '0;
                    high_next  = high_init;
                    steps_next = '0;
                    state_next = S_SQ_TEST;
                end
            end
            S_SQ_TEST:
            begin
                if ((steps_reg >= limit_reg) || (span < ROOT_W'(stop_reg)))
                begin
                    root_next  = half;
                    state_next = S_SQ_END;
                end
                else
                begin
                    ma_next     = WIDE_W'(half);
                    mb_next     = half;
                    mlast_next  = MUL_LAST_NARROW;
                    mstart_next = 1'b1;
                    state_next  = S_SQ_MUL;
                end
            end
            S_SQ_MUL:
            begin
                if (mdone)
                begin
                    steps_next = steps_reg + 1'b1;
                    state_next = S_SQ_TEST;
                    if (mprod > x_reg)
                    begin
                        high_next = mb_reg;
                    end
                    else if (mprod < x_reg)
                    begin
                        low_next = mb_reg;
                    end
                    else
                    begin
                        root_next  = mb_reg;
                        state_next = S_SQ_END;
                    end
                end
            end
            S_SQ_END:
            begin
                if (sel_reg)
                begin
                    dist_out_next = (root_reg > OUT_MAX) ? '1 :
                                    root_reg[SIDE_WIDTH-1:0];
                    status_next   = STAT_OK;
                    state_next    = S_OUT;
                end
                else if (root_reg == '0)
                begin
                    rin_out_next  = '0;
                    rc_out_next   = '0;
                    dist_out_next = '0;
                    status_next   = STAT_NOT_TRI;
                    state_next    = S_OUT;
                end
                else
                begin
                    area_next   = root_reg;
                    dnum_next   = WIDE_W'(root_reg) << (FRACTION_BITS + 1);
                    dden_next   = sum_reg;
                    dstart_next = 1'b1;
                    state_next  = S_D1;
                end
            end
            S_D1:
            begin
                if (ddone)
                begin
                    rin_next    = (dquot[WIDE_W-1:ROOT_W] != '0) ? '1 :
                                  dquot[ROOT_W-1:0];
                    ma_next     = WIDE_W'(ra);
                    mb_next     = rb;
                    mlast_next  = MUL_LAST_NARROW;
                    mstart_next = 1'b1;
                    state_next  = S_M4;
                end
            end
            S_M4:
            begin
                if (mdone)
                begin
                    ma_next     = mprod;
                    mb_next     = rc;
                    mlast_next  = MUL_LAST_WIDE;
                    mstart_next = 1'b1;
                    state_next  = S_M5;
                end
            end
            S_M5:
            begin
                if (mdone)
                begin
                    dnum_next   = mprod >> (FRACTION_BITS + 2);
                    dden_next   = area_reg;
                    dstart_next = 1'b1;
                    state_next  = S_D2;
                end
            end
            S_D2:
            begin
                if (ddone)
                begin
                    rc_out_next  = (dquot[WIDE_W-1:SIDE_WIDTH] != '0) ? '1 :
                                   dquot[SIDE_WIDTH-1:0];
                    rin_out_next = (rin_reg > OUT_MAX) ? '1 :
                                   rin_reg[SIDE_WIDTH-1:0];
                    rint_next    = rint_sat;
                    ma_next      = WIDE_W'(rint_sat);
                    mb_next      = ROOT_W'(rint_sat);
                    mlast_next   = MUL_LAST_NARROW;
                    mstart_next  = 1'b1;
                    state_next   = S_M6;
                end
            end
            S_M6:
            begin
                if (mdone)
                begin
                    rsq_next    = mprod;
                    ma_next     = WIDE_W'(rint_reg);
                    mb_next     = rin_reg;
                    mlast_next  = MUL_LAST_NARROW;
                    mstart_next = 1'b1;
                    state_next  = S_M7;
                end
            end
            S_M7:
            begin
                if (mdone)
                begin
                    if (rsq_reg < two_rr)
                    begin
                        dist_out_next = '0;
                        status_next   = STAT_NEG_RAD;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        x_next     = rsq_reg - two_rr;
                        sel_next   = 1'b1;
                        state_next = S_SQ_INIT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mstart_reg <= 1'b0;
            mlast_reg  <= MUL_LAST_NARROW;
            dstart_reg <= 1'b0;
            limit_reg  <= LIMIT_RESET;
            stop_reg   <= STOP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            mstart_reg <= mstart_next;
            mlast_reg  <= mlast_next;
            dstart_reg <= dstart_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ITER_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_STOP_WIDTH: stop_reg  <= cfg_data[STOP_W-1:0];
                    default:        limit_reg <= limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        sum_reg      <= sum_next;
        x_reg        <= x_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        steps_reg    <= steps_next;
        root_reg     <= root_next;
        sel_reg      <= sel_next;
        area_reg     <= area_next;
        rin_reg      <= rin_next;
        rint_reg     <= rint_next;
        rsq_reg      <= rsq_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        dnum_reg     <= dnum_next;
        dden_reg     <= dden_next;
        rin_out_reg  <= rin_out_next;
        rc_out_reg   <= rc_out_next;
        dist_out_reg <= dist_out_next;
        status_reg   <= status_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign in_radius       = rin_out_reg;
    assign circum_radius   = rc_out_reg;
    assign center_distance = dist_out_reg;
    assign status          = status_reg;

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    a_not_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_NOT_TRI)) |->
        ((in_radius == '0) && (circum_radius == '0) && (center_distance == '0)))
        else $error("non-triangle result carries nonzero radii");

    a_neg_rad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_NEG_RAD)) |-> (center_distance == '0))
        else $error("negative radicand with nonzero distance");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mdone && ddone))
        else $error("multiplier and divider finished together");

endmodule
